/* src/vlpd_pkg.sv */
// ----------------------------------------------------------------------------
// vlpd_pkg
// Shared types and constants for the varint length-prefix deframer.
// ----------------------------------------------------------------------------
package vlpd_pkg;

  localparam int LEN_BITS         = 32;
  localparam int MAX_PREFIX_BYTES = 5;

  localparam int CNT_W  = $clog2(MAX_PREFIX_BYTES + 1);
  localparam int WIDE_W = LEN_BITS + 7 * MAX_PREFIX_BYTES;
  localparam int SH_W   = $clog2(WIDE_W);

  localparam logic [7:0] CONT_BIT   = 8'b1000_0000;
  localparam logic [7:0] VALUE_BITS = 8'b0111_1111;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_ABORT    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_dropped;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        end_of_message;
    kind_t       kind;
    logic [31:0] message_length;
  } result_t;

  function automatic logic [31:0] len32(input logic [LEN_BITS-1:0] a);
    logic [63:0] w;
    w = 64'(a);
    return w[31:0];
  endfunction

endpackage

/* src/vlpd_in_stage.sv */
// ----------------------------------------------------------------------------
// vlpd_in_stage
// Input register: holds one received beat until the parser consumes it.
// ----------------------------------------------------------------------------
module vlpd_in_stage
  import vlpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  held_valid,
  output item_t held_item,
  input  logic  take
);

  logic  hv;
  item_t hi;

  assign in_ready   = !hv || take;
  assign held_valid = hv;
  assign held_item  = hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
    end else if (in_ready) begin
      hv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hi <= in_item;
    end
  end

endmodule

/* src/vlpd_core.sv */
// ----------------------------------------------------------------------------
// vlpd_core
// Parser state and single-pass decode of one byte into at most one result.
// ----------------------------------------------------------------------------
module vlpd_core
  import vlpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  input  logic    out_space,
  output logic    take,
  output logic    res_has,
  output result_t res
);

  logic                in_payload, in_payload_next;
  logic [LEN_BITS-1:0] acc, acc_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [LEN_BITS-1:0] rem, rem_next;

  logic [SH_W-1:0]     shamt;
  logic [WIDE_W-1:0]   shifted;
  logic                val_ovf;
  logic [LEN_BITS-1:0] acc_or;
  logic [CNT_W-1:0]    cnt_inc;
  logic                too_long;
  logic [LEN_BITS-1:0] rem_dec;
  logic [7:0]          vbits;

  assign vbits    = item.rx_byte & VALUE_BITS;
  assign shamt    = SH_W'(cnt) * SH_W'(7);
  assign shifted  = WIDE_W'(vbits[6:0]) << shamt;
  assign val_ovf  = |shifted[WIDE_W-1:LEN_BITS];
  assign acc_or   = acc | shifted[LEN_BITS-1:0];
  assign cnt_inc  = cnt + 1'b1;
  assign too_long = ((item.rx_byte & CONT_BIT) != 8'd0) &&
                    (cnt_inc >= CNT_W'(MAX_PREFIX_BYTES));
  assign rem_dec  = rem - 1'b1;

  assign take = item_valid && (out_space || !res_has);

  always_comb begin
    in_payload_next = in_payload;
    acc_next        = acc;
    cnt_next        = cnt;
    rem_next        = rem;
    res_has         = 1'b0;
    res             = '0;
    if (item.link_dropped) begin
      if (in_payload || cnt != '0) begin
        res_has            = 1'b1;
        res.end_of_message = 1'b1;
        res.kind           = KIND_ABORT;
        res.message_length = in_payload ? len32(acc) : 32'd0;
      end
      in_payload_next = 1'b0;
      acc_next        = '0;
      cnt_next        = '0;
      rem_next        = '0;
    end else if (in_payload) begin
      res_has            = 1'b1;
      res.payload_byte   = item.rx_byte;
      res.end_of_message = (rem_dec == '0);
      res.kind           = KIND_DATA;
      res.message_length = len32(acc);
      if (rem_dec == '0) begin
        in_payload_next = 1'b0;
        acc_next        = '0;
        cnt_next        = '0;
        rem_next        = '0;
      end else begin
        rem_next = rem_dec;
      end
    end else if (val_ovf || too_long) begin
      res_has            = 1'b1;
      res.end_of_message = 1'b1;
      res.kind           = KIND_OVERFLOW;
      acc_next           = '0;
      cnt_next           = '0;
      rem_next           = '0;
    end else if ((item.rx_byte & CONT_BIT) != 8'd0) begin
      acc_next = acc_or;
      cnt_next = cnt_inc;
    end else if (acc_or == '0) begin
      res_has            = 1'b1;
      res.end_of_message = 1'b1;
      res.kind           = KIND_EMPTY;
      acc_next           = '0;
      cnt_next           = '0;
      rem_next           = '0;
    end else begin
      in_payload_next = 1'b1;
      acc_next        = acc_or;
      cnt_next        = '0;
      rem_next        = acc_or;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      acc        <= '0;
      cnt        <= '0;
      rem        <= '0;
    end else if (take) begin
      in_payload <= in_payload_next;
      acc        <= acc_next;
      cnt        <= cnt_next;
      rem        <= rem_next;
    end
  end

endmodule

/* src/varint_length_prefix_deframer.sv */
// ----------------------------------------------------------------------------
// varint_length_prefix_deframer
// Splits a byte stream into messages framed by a base-128 length prefix.
// ----------------------------------------------------------------------------
// The block accepts one byte beat per clock unless stalled and gives at most one
// result beat for it. A beat passes through an input register, a combinational
// decode that updates the parser state, and an output register that presents its
// result. Prefix bytes give no result unless the prefix overflows or decodes to an
// empty message; overflow, empty message and a link drop inside a message each
// give one beat with end_of_message set, while a link drop between messages gives
// none. A full output register that is not drained stalls the input only when the
// waiting byte would produce a result.
module varint_length_prefix_deframer
  import vlpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        link_dropped,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        end_of_message,
  output logic [1:0]  result_kind,
  output logic [31:0] message_length
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    res_has;
  result_t res;
  result_t out_res;
  logic    ov;
  logic    out_space;

  assign in_item.rx_byte      = rx_byte;
  assign in_item.link_dropped = link_dropped;
  assign out_space            = !ov || out_ready;

  vlpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  vlpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (held_valid),
    .item       (held_item),
    .out_space  (out_space),
    .take       (take),
    .res_has    (res_has),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_space) begin
      ov <= take && res_has;
    end
  end

  always_ff @(posedge clk) begin
    if (out_space && take && res_has) begin
      out_res <= res;
    end
  end

  assign out_valid      = ov;
  assign payload_byte   = out_res.payload_byte;
  assign end_of_message = out_res.end_of_message;
  assign result_kind    = out_res.kind;
  assign message_length = out_res.message_length;

  a_nondata_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_DATA |-> end_of_message && payload_byte == 8'd0)
    else $error("Non-data result without end of message or with payload.");

  a_no_len_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_EMPTY || result_kind == KIND_OVERFLOW)
    |-> message_length == 32'd0)
    else $error("Empty or overflow result carries a length.");

  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("Input not ready after reset.");

  a_data_has_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_DATA && LEN_BITS <= 32 |-> message_length != 32'd0)
    else $error("Payload beat with zero message length.");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the varint length-prefix deframer. A queue of byte
// beats is built up front: a directed set covering empty, padded, overflowing,
// over-long and dropped frames, then random well-formed frames mixed with
// noise and broken frames. A clocked driver offers the beats with random gaps
// and runs a bit-accurate parser model on every accepted beat. A clocked
// monitor drains results with random stalls and one or more long hold-offs,
// and checks each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import vlpd_pkg::*;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte        = 8'h00;
  logic        link_dropped   = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  payload_byte;
  logic        end_of_message;
  logic [1:0]  result_kind;
  logic [31:0] message_length;

  varint_length_prefix_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .link_dropped   (link_dropped),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .end_of_message (end_of_message),
    .result_kind    (result_kind),
    .message_length (message_length)
  );

  always #10 clk = ~clk;

  localparam logic [63:0] LEN_MASK = (64'd1 << LEN_BITS) - 64'd1;

  item_t   pending_beats[$];
  result_t due_results[$];

  bit          in_frame;
  logic [63:0] frame_len;
  int unsigned prefix_count;
  logic [63:0] bytes_left;

  int n_accepted;
  int n_results;
  int n_errors;
  int idle_drops;
  int kind_seen [4];
  int send_gap;
  int send_mode;
  int recv_stall;
  int recv_mode;
  int hold_left;
  int holds_done;

  function automatic int pace(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic void parser_clear();
    in_frame     = 1'b0;
    frame_len    = '0;
    prefix_count = 0;
    bytes_left   = '0;
  endfunction

  function automatic bit deframe_predict(input logic [7:0] b, input logic drop,
                                         output result_t r);
    logic [63:0] v;
    logic [63:0] len;
    int unsigned shift;
    int unsigned room;
    bit          ovf;
    r = '0;
    if (drop) begin
      if (in_frame || prefix_count != 0) begin
        len = in_frame ? frame_len : 64'd0;
        parser_clear();
        r.end_of_message = 1'b1;
        r.kind           = KIND_ABORT;
        r.message_length = len[31:0];
        return 1'b1;
      end
      parser_clear();
      return 1'b0;
    end
    if (in_frame) begin
      bytes_left = (bytes_left - 64'd1) & LEN_MASK;
      r.payload_byte   = b;
      r.kind           = KIND_DATA;
      r.message_length = frame_len[31:0];
      if (bytes_left == 0) begin
        r.end_of_message = 1'b1;
        parser_clear();
      end
      return 1'b1;
    end
    v     = 64'(b & VALUE_BITS);
    shift = 7 * prefix_count;
    ovf   = 1'b0;
    if (shift >= LEN_BITS) begin
      ovf = (v != 0);
    end else begin
      room = LEN_BITS - shift;
      if (room < 7 && (v >> room) != 0) ovf = 1'b1;
      else frame_len = (frame_len | (v << shift)) & LEN_MASK;
    end
    prefix_count++;
    if (!ovf && (b & CONT_BIT) != 0 && prefix_count >= MAX_PREFIX_BYTES) ovf = 1'b1;
    if (ovf) begin
      parser_clear();
      r.end_of_message = 1'b1;
      r.kind           = KIND_OVERFLOW;
      return 1'b1;
    end
    if ((b & CONT_BIT) != 0) return 1'b0;
    if (frame_len == 0) begin
      parser_clear();
      r.end_of_message = 1'b1;
      r.kind           = KIND_EMPTY;
      return 1'b1;
    end
    in_frame     = 1'b1;
    bytes_left   = frame_len;
    prefix_count = 0;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             n_results, what, got, want);
    n_errors++;
  endtask

  task automatic push_raw(input logic [7:0] b, input logic drop);
    item_t it;
    it.rx_byte      = b;
    it.link_dropped = drop;
    pending_beats.push_back(it);
  endtask

  task automatic push_prefix(input logic [31:0] len, input int extra);
    int n;
    logic [7:0] b;
    n = 1;
    while (n < MAX_PREFIX_BYTES && (len >> (7 * n)) != 0) n++;
    n = (n + extra > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES : n + extra;
    for (int i = 0; i < n; i++) begin
      b = 8'((len >> (7 * i)) & 32'h7F);
      if (i < n - 1) b = b | CONT_BIT;
      push_raw(b, 1'b0);
    end
  endtask

  // Sends a prefix for len and then nsend payload beats; a short frame is cut
  // off by a link drop.
  task automatic push_frame(input logic [31:0] len, input int extra, input int nsend);
    push_prefix(len, extra);
    for (int i = 0; i < nsend; i++) push_raw(8'($urandom), 1'b0);
    if (nsend < len) push_raw(8'($urandom), 1'b1);
  endtask

  task automatic build_stimulus();
    int pick;
    int len;
    int n;
    push_raw(8'h00, 1'b0);
    push_raw(8'h80, 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'h01, 1'b0);
    push_raw(8'hFF, 1'b0);
    push_raw(8'hFF, 1'b1);
    idle_drops++;
    push_raw(8'h81, 1'b0);
    push_raw(8'h00, 1'b1);
    push_raw(8'h03, 1'b0);
    push_raw(8'h11, 1'b0);
    push_raw(8'hA5, 1'b1);
    for (int i = 0; i < 4; i++) push_raw(8'hFF, 1'b0);
    push_raw(8'h7F, 1'b0);
    for (int i = 0; i < MAX_PREFIX_BYTES; i++) push_raw(8'h80, 1'b0);
    for (int i = 0; i < 4; i++) push_raw(8'hFF, 1'b0);
    push_raw(8'h0F, 1'b0);
    push_raw(8'h00, 1'b1);

    while (pending_beats.size() - idle_drops < 1330) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        n = $urandom_range(0, 99);
        if (n < 8) len = 0;
        else if (n < 75) len = $urandom_range(1, 12);
        else if (n < 96) len = $urandom_range(13, 64);
        else len = $urandom_range(65, 400);
        push_frame(len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, len);
      end else if (pick < 76) begin
        len = $urandom;
        if (len == 0) len = 1;
        push_frame(len, 0, $urandom_range(0, 4));
      end else if (pick < 84) begin
        n = $urandom_range(0, 12);
        push_frame($urandom_range(1, 12), 0, (n > 0) ? n - 1 : 0);
      end else if (pick < 91) begin
        for (int i = 0; i < MAX_PREFIX_BYTES - 1; i++)
          push_raw(CONT_BIT | 8'($urandom_range(0, 127)), 1'b0);
        if ($urandom_range(0, 1) == 0)
          push_raw(8'($urandom_range(16, 127)) | (CONT_BIT & 8'($urandom)), 1'b0);
        else
          push_raw(CONT_BIT | 8'($urandom_range(0, 127)), 1'b0);
      end else if (pick < 95) begin
        n = $urandom_range(1, MAX_PREFIX_BYTES - 1);
        for (int i = 0; i < n; i++) push_raw(CONT_BIT | 8'($urandom_range(0, 127)), 1'b0);
        push_raw(8'($urandom), 1'b1);
      end else if (pick < 97) begin
        push_raw(8'($urandom), 1'b1);
        idle_drops++;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) push_raw(8'($urandom), 1'($urandom));
        push_raw(8'($urandom), 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    logic    nxt_valid;
    item_t   it;
    result_t r;
    if (rst) begin
      in_valid <= 1'b0;
      parser_clear();
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        n_accepted++;
        if (n_accepted % 40 == 0) send_mode = $urandom_range(0, 2);
        if (deframe_predict(rx_byte, link_dropped, r)) due_results.push_back(r);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_beats.size() != 0) begin
          it = pending_beats.pop_front();
          rx_byte      <= it.rx_byte;
          link_dropped <= it.link_dropped;
          nxt_valid = 1'b1;
          send_gap  = pace(send_mode);
        end
      end
      in_valid <= nxt_valid;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected beat, payload_byte", 32'(payload_byte), 32'h0);
        end else begin
          want = due_results.pop_front();
          if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
          if (end_of_message !== want.end_of_message)
            report_mismatch("end_of_message", 32'(end_of_message),
                            32'(want.end_of_message));
          if (result_kind !== want.kind)
            report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
          if (message_length !== want.message_length)
            report_mismatch("message_length", message_length, want.message_length);
        end
        kind_seen[result_kind]++;
        n_results <= n_results + 1;
        if ((n_results + 1) % 64 == 0) recv_mode = $urandom_range(0, 2);
        recv_stall = pace(recv_mode);
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      out_ready <= (recv_stall == 0) && (hold_left == 0);
    end
  end

  // The receiver backs off for a long stretch twice while beats keep coming.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && n_results >= 100 + 400 * holds_done) begin
      hold_left  <= 300;
      holds_done <= holds_done + 1;
    end
  end

  initial begin
    send_mode = 2;
    recv_mode = 2;
    build_stimulus();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || due_results.size() != 0);
    repeat (10) @(negedge clk);
    $display("Accepted %0d byte beats and checked %0d results: %0d data, %0d empty,",
             n_accepted, n_results, kind_seen[KIND_DATA], kind_seen[KIND_EMPTY]);
    $display("%0d aborted, %0d overflow; %0d mismatches.",
             kind_seen[KIND_ABORT], kind_seen[KIND_OVERFLOW], n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Timed out with %0d beats pending and %0d results due.",
             pending_beats.size(), due_results.size());
    $display("FAIL");
    $finish;
  end

endmodule
